@@ rtl/core/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared width default and case codes for the rotation matrix to quaternion
// converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // default element width, signed Q2.(width-2)
    localparam int unsigned DATA_WIDTH_DEF = 16;

    // which quaternion element is formed from the square root
    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_M00   = 2'd1,
        CASE_M11   = 2'd2,
        CASE_M22   = 2'd3
    } t_case;

endpackage

@@ rtl/core/rmq_if.sv @@
// ----------------------------------------------------------------------------
// rmq interfaces
// Valid/ready channels for matrix beats in and quaternion beats out.
// ----------------------------------------------------------------------------
interface rmq_mat_if #(
    parameter int unsigned DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        input  ready
    );
    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        output ready
    );
endinterface

interface rmq_quat_if #(
    parameter int unsigned DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] qw;
    logic signed [DATA_WIDTH-1:0] qx;
    logic signed [DATA_WIDTH-1:0] qy;
    logic signed [DATA_WIDTH-1:0] qz;
    logic        [1:0]            case_used;
    logic                         invalid;

    modport source (
        output valid, qw, qx, qy, qz, case_used, invalid,
        input  ready
    );
    modport sink (
        input  valid, qw, qx, qy, qz, case_used, invalid,
        output ready
    );
endinterface

@@ rtl/core/rotation_matrix_to_quaternion_top.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Converts a 3x3 rotation matrix in signed Q2.F to a unit quaternion in Q2.F.
//
// i_mat carries one matrix per beat (valid/ready), o_quat one quaternion per
// beat together with the case used and an invalid flag (non-positive
// radicand, components forced to zero).
// Stages: one select stage, DATA_WIDTH square root stages (one root bit
// each), DATA_WIDTH+1 divide stages (overflow check, then one quotient bit
// each in three parallel lanes) and the output register.
// Throughput: one matrix per cycle while the receiver takes results.
// Reset clears every valid bit; the pipeline is empty after reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and i_mat.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top #(
    parameter int unsigned DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);
    import rmq_pkg::*;

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned F  = W - 2;
    localparam int unsigned RW = W + 1;
    localparam int unsigned SW = 2 * W + 1;
    localparam int unsigned DW = W + 1;
    localparam int unsigned XW = 2 * W + 2;

    localparam logic signed [W+2:0] QONE   = (W+3)'(2 ** F);
    localparam logic        [W-1:0] QMAX_U = {1'b0, {(W-1){1'b1}}};
    localparam logic        [W-1:0] QMIN_U = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic       v;
        t_case      sel;
        logic       bad;
        logic [2:0] dneg;
    } t_ctl;

    logic en;

    // square root stages
    t_ctl            r_sq_ctl  [0:W];
    logic [SW-1:0]   r_sq_rem  [0:W];
    logic [W-1:0]    r_sq_res  [0:W];
    logic [DW-1:0]   r_sq_dmag [0:W][0:2];

    // divide stages
    t_ctl            r_dv_ctl  [0:W];
    logic [W-1:0]    r_dv_root [0:W];
    logic [2:0]      r_dv_ovf  [0:W];
    logic [XW-1:0]   r_dv_x    [0:W][0:2];
    logic [W-1:0]    r_dv_q    [0:W][0:2];

    // output register
    logic            r_o_valid;
    logic [W-1:0]    r_o_qw, r_o_qx, r_o_qy, r_o_qz;
    logic [1:0]      r_o_case;
    logic            r_o_invalid;

    // pipeline advances unless a result is waiting on a stalled receiver
    assign en          = !r_o_valid || o_quat.ready;
    assign i_mat.ready = en;

    // ------------------------------------------------------------------
    // case select, radicand and off-diagonal terms
    // ------------------------------------------------------------------
    logic signed [W+2:0] x00, x01, x02, x10, x11, x12, x20, x21, x22;
    logic signed [W+2:0] tr, rad, d0, d1, d2;
    logic signed [W+2:0] m0, m1, m2;
    t_case               n_sel;
    t_ctl                n_ctl;

    assign x00 = (W+3)'(i_mat.m00);
    assign x01 = (W+3)'(i_mat.m01);
    assign x02 = (W+3)'(i_mat.m02);
    assign x10 = (W+3)'(i_mat.m10);
    assign x11 = (W+3)'(i_mat.m11);
    assign x12 = (W+3)'(i_mat.m12);
    assign x20 = (W+3)'(i_mat.m20);
    assign x21 = (W+3)'(i_mat.m21);
    assign x22 = (W+3)'(i_mat.m22);
    assign tr  = x00 + x11 + x22;

    always_comb begin
        if (tr > 0) begin
            n_sel = CASE_TRACE;
            rad   = QONE + tr;
            d0    = x21 - x12;
            d1    = x02 - x20;
            d2    = x10 - x01;
        end else if (x00 > x11 && x00 > x22) begin
            n_sel = CASE_M00;
            rad   = QONE + x00 - x11 - x22;
            d0    = x21 - x12;
            d1    = x01 + x10;
            d2    = x02 + x20;
        end else if (x11 > x22) begin
            n_sel = CASE_M11;
            rad   = QONE + x11 - x00 - x22;
            d0    = x02 - x20;
            d1    = x01 + x10;
            d2    = x12 + x21;
        end else begin
            n_sel = CASE_M22;
            rad   = QONE + x22 - x00 - x11;
            d0    = x10 - x01;
            d1    = x02 + x20;
            d2    = x12 + x21;
        end
    end

    assign m0 = d0[W+2] ? -d0 : d0;
    assign m1 = d1[W+2] ? -d1 : d1;
    assign m2 = d2[W+2] ? -d2 : d2;

    always_comb begin
        n_ctl.v    = i_mat.valid;
        n_ctl.sel  = n_sel;
        n_ctl.bad  = (rad <= 0);
        n_ctl.dneg = {d2[W+2], d1[W+2], d0[W+2]};
    end

    // select stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_ctl[0] <= '0;
        end else if (en) begin
            r_sq_ctl[0] <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]     <= n_ctl.bad ? '0 : (SW'(rad[RW-1:0]) << F);
            r_sq_res[0]     <= '0;
            r_sq_dmag[0][0] <= m0[DW-1:0];
            r_sq_dmag[0][1] <= m1[DW-1:0];
            r_sq_dmag[0][2] <= m2[DW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // square root, one result bit per stage, msb first
    // ------------------------------------------------------------------
    for (genvar k = 0; k < W; k++) begin : g_sq
        localparam int unsigned I = W - 1 - k;
        logic [SW-1:0] trial;
        logic          take;

        assign trial = (SW'(r_sq_res[k]) << (I + 1)) + (SW'(1) << (2 * I));
        assign take  = (r_sq_rem[k] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_ctl[k+1] <= '0;
            end else if (en) begin
                r_sq_ctl[k+1] <= r_sq_ctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k+1]  <= take ? (r_sq_rem[k] - trial) : r_sq_rem[k];
                r_sq_res[k+1]  <= r_sq_res[k] | (take ? (W'(1) << I) : '0);
                r_sq_dmag[k+1] <= r_sq_dmag[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // divide setup: rounded quotient (2*d*2^F + 2*root) / (4*root)
    // ------------------------------------------------------------------
    logic [XW-1:0] dv_ylim;
    logic [XW-1:0] dv_x0 [0:2];
    logic [2:0]    dv_ovf0;

    assign dv_ylim = XW'(r_sq_res[W]) << (W + 2);

    for (genvar j = 0; j < 3; j++) begin : g_dv0
        assign dv_x0[j]   = (XW'(r_sq_dmag[W][j]) << (F + 1)) + (XW'(r_sq_res[W]) << 1);
        assign dv_ovf0[j] = (dv_x0[j] >= dv_ylim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_ctl[0] <= '0;
        end else if (en) begin
            r_dv_ctl[0] <= r_sq_ctl[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_root[0] <= r_sq_res[W];
            r_dv_ovf[0]  <= dv_ovf0;
            r_dv_x[0]    <= dv_x0;
            r_dv_q[0][0] <= '0;
            r_dv_q[0][1] <= '0;
            r_dv_q[0][2] <= '0;
        end
    end

    // ------------------------------------------------------------------
    // restoring division, one quotient bit per stage in three lanes
    // ------------------------------------------------------------------
    for (genvar t = 0; t < W; t++) begin : g_dv
        localparam int unsigned I = W - 1 - t;
        logic [XW-1:0] ysh;
        logic [XW-1:0] x_nx [0:2];
        logic [W-1:0]  q_nx [0:2];

        assign ysh = XW'(r_dv_root[t]) << (I + 2);

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                if (r_dv_x[t][j] >= ysh) begin
                    x_nx[j] = r_dv_x[t][j] - ysh;
                    q_nx[j] = r_dv_q[t][j] | (W'(1) << I);
                end else begin
                    x_nx[j] = r_dv_x[t][j];
                    q_nx[j] = r_dv_q[t][j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_ctl[t+1] <= '0;
            end else if (en) begin
                r_dv_ctl[t+1] <= r_dv_ctl[t];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_root[t+1] <= r_dv_root[t];
                r_dv_ovf[t+1]  <= r_dv_ovf[t];
                r_dv_x[t+1]    <= x_nx;
                r_dv_q[t+1]    <= q_nx;
            end
        end
    end

    // ------------------------------------------------------------------
    // saturate, sign and place the components
    // ------------------------------------------------------------------
    logic [W:0]   big_w;
    logic [W-1:0] big;
    logic [W-1:0] comp [0:2];
    logic [W-1:0] n_qw, n_qx, n_qy, n_qz;
    t_ctl         fc;

    assign fc    = r_dv_ctl[W];
    assign big_w = ((W+1)'(r_dv_root[W]) + (W+1)'(1)) >> 1;
    assign big   = (big_w > (W+1)'(QMAX_U)) ? QMAX_U : big_w[W-1:0];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (fc.dneg[j]) begin
                comp[j] = (r_dv_ovf[W][j] || r_dv_q[W][j] > QMIN_U) ? QMIN_U
                                                                     : (~r_dv_q[W][j] + W'(1));
            end else begin
                comp[j] = (r_dv_ovf[W][j] || r_dv_q[W][j] > QMAX_U) ? QMAX_U
                                                                     : r_dv_q[W][j];
            end
        end
    end

    always_comb begin
        case (fc.sel)
            CASE_TRACE: begin
                n_qw = big;     n_qx = comp[0]; n_qy = comp[1]; n_qz = comp[2];
            end
            CASE_M00: begin
                n_qw = comp[0]; n_qx = big;     n_qy = comp[1]; n_qz = comp[2];
            end
            CASE_M11: begin
                n_qw = comp[0]; n_qx = comp[1]; n_qy = big;     n_qz = comp[2];
            end
            CASE_M22: begin
                n_qw = comp[0]; n_qx = comp[1]; n_qy = comp[2]; n_qz = big;
            end
            default: begin
                n_qw = '0;      n_qx = '0;      n_qy = '0;      n_qz = '0;
            end
        endcase
        if (fc.bad) begin
            n_qw = '0;
            n_qx = '0;
            n_qy = '0;
            n_qz = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= fc.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_qw      <= n_qw;
            r_o_qx      <= n_qx;
            r_o_qy      <= n_qy;
            r_o_qz      <= n_qz;
            r_o_case    <= fc.sel;
            r_o_invalid <= fc.bad;
        end
    end

    assign o_quat.valid     = r_o_valid;
    assign o_quat.qw        = r_o_qw;
    assign o_quat.qx        = r_o_qx;
    assign o_quat.qy        = r_o_qy;
    assign o_quat.qz        = r_o_qz;
    assign o_quat.case_used = r_o_case;
    assign o_quat.invalid   = r_o_invalid;

endmodule

@@ rtl/core/rmq_chk.sv @@
// ----------------------------------------------------------------------------
// rmq_chk
// Port-level checks for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
module rmq_chk #(
    parameter int unsigned DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [DATA_WIDTH-1:0] i_qw,
    input logic signed [DATA_WIDTH-1:0] i_qx,
    input logic signed [DATA_WIDTH-1:0] i_qy,
    input logic signed [DATA_WIDTH-1:0] i_qz,
    input logic        [1:0]            i_case_used,
    input logic                         i_invalid
);
    import rmq_pkg::*;

    // a waiting beat stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    // invalid beats carry zero components
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_invalid |-> i_qw == 0 && i_qx == 0 && i_qy == 0 && i_qz == 0)
        else $error("invalid beat with nonzero components");

    // positive trace always has a positive radicand
    a_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_case_used == CASE_TRACE |-> !i_invalid)
        else $error("trace case flagged invalid");

    // the root element of a valid beat is positive
    a_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_invalid |->
            (i_case_used == CASE_TRACE && i_qw > 0) ||
            (i_case_used == CASE_M00 && i_qx > 0) ||
            (i_case_used == CASE_M11 && i_qy > 0) ||
            (i_case_used == CASE_M22 && i_qz > 0))
        else $error("root element not positive");

    // pipeline is empty after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind rotation_matrix_to_quaternion_top rmq_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rmq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_quat.valid),
    .i_out_ready (o_quat.ready),
    .i_qw        (o_quat.qw),
    .i_qx        (o_quat.qx),
    .i_qy        (o_quat.qy),
    .i_qz        (o_quat.qz),
    .i_case_used (o_quat.case_used),
    .i_invalid   (o_quat.invalid)
);
